[rtl/encoder_velocity_lowpass_top_assert.svh]
// Assertion macros used by the encoder velocity low-pass back end.
`ifndef ENCODER_VELOCITY_LOWPASS_TOP_ASSERT_SVH
`define ENCODER_VELOCITY_LOWPASS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EVL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/evl_pkg.sv]
// Types and constants of the encoder velocity low-pass block.
package evl_pkg;

    localparam int unsigned MOTORS    = 2;
    localparam int unsigned MAG_W     = 32;
    localparam int unsigned SCALE_W   = 26;
    localparam int unsigned PROD_W    = MAG_W + SCALE_W;
    localparam int unsigned ELAPSED_W = 24;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned DEN_W     = CFG_W + ELAPSED_W;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned QUOT_W    = 32;
    localparam int unsigned STEP_W    = $clog2(QUOT_W);
    localparam int unsigned RATE_W    = 32;

    localparam logic [SCALE_W-1:0] US_PER_MINUTE = 26'd60_000_000;

    localparam logic [CFG_W-1:0] RST_COUNTS_PER_REV = 16'd600;
    localparam logic [CFG_W-1:0] RST_COEF_FEEDBACK  = 16'd63509;
    localparam logic [CFG_W-1:0] RST_COEF_INPUT     = 16'd1014;

    typedef enum logic [1:0] {
        CFG_COUNTS_PER_REV = 2'd0,
        CFG_COEF_FEEDBACK  = 2'd1,
        CFG_COEF_INPUT     = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [RATE_W-1:0] count_left;
        logic signed [RATE_W-1:0] count_right;
        logic [ELAPSED_W-1:0]     elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_left;
        logic signed [RATE_W-1:0] rate_right;
        logic                     clipped;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       index;
        logic [CFG_W-1:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic [CFG_W-1:0] counts_per_rev;
        logic [CFG_W-1:0] coef_feedback;
        logic [CFG_W-1:0] coef_input;
    } t_cfg_set;

    typedef struct packed {
        logic [MOTORS-1:0][MAG_W-1:0] mag;
        logic [MOTORS-1:0]            neg;
        logic [MOTORS-1:0]            zero;
        logic [ELAPSED_W-1:0]         elapsed_us;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_rd;

    typedef struct packed {
        logic              busy;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

[rtl/evl_if.sv]
// Valid/ready channel carrying one item of a given payload type.
interface evl_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/evl_front.sv]
// Front end: takes input items, forms per-motor count deltas and queues the jobs.
module evl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    evl_if.sink           i_in,
    input  logic          i_full,
    output evl_pkg::t_q_wr o_wr
);

    logic [evl_pkg::MOTORS-1:0][evl_pkg::MAG_W-1:0] r_last;
    logic [evl_pkg::MOTORS-1:0][evl_pkg::MAG_W-1:0] w_now;
    logic [evl_pkg::MOTORS-1:0][evl_pkg::MAG_W-1:0] w_delta;
    logic                                           w_push;

    assign i_in.ready = !i_full;
    assign w_push     = i_in.valid && !i_full;
    assign w_now[0]   = i_in.data.count_left;
    assign w_now[1]   = i_in.data.count_right;

    always_comb begin
        o_wr.push            = w_push;
        o_wr.job.elapsed_us  = i_in.data.elapsed_us;
        for (int k = 0; k < evl_pkg::MOTORS; k++) begin
            w_delta[k]      = w_now[k] - r_last[k];
            o_wr.job.neg[k]  = w_delta[k][evl_pkg::MAG_W-1];
            o_wr.job.zero[k] = (w_delta[k] == '0);
            o_wr.job.mag[k]  = w_delta[k][evl_pkg::MAG_W-1] ? ('0 - w_delta[k]) : w_delta[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (w_push) begin
            r_last <= w_now;
        end
    end

endmodule

[rtl/evl_fifo.sv]
// Short queue of jobs between the front end and the back end.
module evl_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  evl_pkg::t_q_wr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output evl_pkg::t_q_rd o_rd
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    evl_pkg::t_job    r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.job   = r_mem[r_rd_ptr];
    assign w_push     = i_wr.push && !o_full;
    assign w_pop      = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/evl_div.sv]
// Restoring divider giving one quotient bit per cycle, with early overflow exit.
module evl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [evl_pkg::PROD_W-1:0]  i_num,
    input  logic [evl_pkg::DEN_W-1:0]   i_den,
    output evl_pkg::t_div_res           o_res
);

    localparam int HI_W = evl_pkg::PROD_W - evl_pkg::FRAC_W;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                       r_state;
    logic [evl_pkg::DEN_W-1:0]    r_den;
    logic [evl_pkg::DEN_W-1:0]    r_rem;
    logic [evl_pkg::QUOT_W-1:0]   r_num_lo;
    logic [evl_pkg::QUOT_W-1:0]   r_quot;
    logic [evl_pkg::STEP_W-1:0]   r_cnt;
    logic                         r_sat;
    logic                         w_over;
    logic [evl_pkg::DEN_W:0]      n_trial;
    logic [evl_pkg::DEN_W:0]      n_diff;
    logic                         n_fit;

    assign w_over  = i_num[evl_pkg::PROD_W-1:evl_pkg::FRAC_W]
                     >= {{(HI_W - evl_pkg::DEN_W){1'b0}}, i_den};
    assign n_trial = {r_rem, r_num_lo[evl_pkg::QUOT_W-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    assign o_res.busy = (r_state == S_RUN);
    assign o_res.sat  = r_sat;
    assign o_res.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sat   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_den    <= i_den;
                        r_quot   <= '0;
                        r_cnt    <= '0;
                        r_rem    <= i_num[evl_pkg::FRAC_W+evl_pkg::DEN_W-1:evl_pkg::FRAC_W];
                        r_num_lo <= {i_num[evl_pkg::FRAC_W-1:0],
                                     {(evl_pkg::QUOT_W - evl_pkg::FRAC_W){1'b0}}};
                        r_sat    <= w_over;
                        r_state  <= w_over ? S_IDLE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem    <= n_fit ? n_diff[evl_pkg::DEN_W-1:0]
                                      : n_trial[evl_pkg::DEN_W-1:0];
                    r_num_lo <= {r_num_lo[evl_pkg::QUOT_W-2:0], 1'b0};
                    r_quot   <= {r_quot[evl_pkg::QUOT_W-2:0], n_fit};
                    if (r_cnt == evl_pkg::STEP_W'(evl_pkg::QUOT_W - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/evl_back.sv]
// Back end: raw speed by division, low-pass filter, saturation and result register.
`include "encoder_velocity_lowpass_top_assert.svh"

module evl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  evl_pkg::t_q_rd    i_q,
    output logic              o_pop,
    input  evl_pkg::t_cfg_set i_cfg,
    evl_if.source             o_out
);

    localparam int M      = evl_pkg::MOTORS;
    localparam int RW     = evl_pkg::RATE_W;
    localparam int PA_W   = evl_pkg::CFG_W + 1 + RW;
    localparam int PB_W   = evl_pkg::CFG_W + 1 + RW + 1;
    localparam int ACC_W  = PB_W + 1;
    localparam int SH_W   = ACC_W - evl_pkg::FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_WAIT, S_RAW, S_FMUL, S_ACC, S_OUT
    } t_state;

    t_state                                   r_state;
    evl_pkg::t_job                            r_job;
    logic [M-1:0][evl_pkg::PROD_W-1:0]        r_m;
    logic [evl_pkg::DEN_W-1:0]                r_den;
    logic signed [RW-1:0]                     r_raw [M];
    logic signed [RW-1:0]                     r_last_raw [M];
    logic signed [RW-1:0]                     r_smoothed [M];
    logic signed [PA_W-1:0]                   r_pa [M];
    logic signed [PB_W-1:0]                   r_pb [M];
    logic                                     r_clip;
    logic                                     r_out_valid;
    evl_pkg::t_out_item                       r_out_data;

    evl_pkg::t_div_res                        w_div [M];
    logic                                     w_start;
    logic                                     w_load;
    logic signed [RW-1:0]                     n_raw [M];
    logic [M-1:0]                             n_raw_clip;
    logic signed [RW:0]                       n_sum [M];
    logic signed [ACC_W-1:0]                  n_acc [M];
    logic signed [SH_W-1:0]                   n_sh [M];
    logic signed [RW-1:0]                     n_filt [M];
    logic [M-1:0]                             n_filt_clip;

    assign w_start     = (r_state == S_DIV);
    assign w_load      = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign o_pop       = (r_state == S_IDLE) && i_q.valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    for (genvar g = 0; g < M; g++) begin : g_div
        evl_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_num   (r_m[g]),
            .i_den   (r_den),
            .o_res   (w_div[g])
        );
    end

    always_comb begin
        for (int k = 0; k < M; k++) begin
            if (r_job.zero[k]) begin
                n_raw[k]      = '0;
                n_raw_clip[k] = 1'b0;
            end else if (w_div[k].sat || w_div[k].quot[evl_pkg::QUOT_W-1]) begin
                n_raw[k]      = r_job.neg[k] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                n_raw_clip[k] = 1'b1;
            end else begin
                n_raw[k]      = r_job.neg[k] ? $signed('0 - w_div[k].quot)
                                             : $signed(w_div[k].quot);
                n_raw_clip[k] = 1'b0;
            end
            n_sum[k] = {r_raw[k][RW-1], r_raw[k]} + {r_last_raw[k][RW-1], r_last_raw[k]};
            n_acc[k] = {{(ACC_W - PA_W){r_pa[k][PA_W-1]}}, r_pa[k]}
                     + {r_pb[k][PB_W-1], r_pb[k]};
            n_sh[k]  = n_acc[k][ACC_W-1:evl_pkg::FRAC_W];
            if (n_sh[k][SH_W-1:RW-1] == '0 || n_sh[k][SH_W-1:RW-1] == '1) begin
                n_filt[k]      = n_sh[k][RW-1:0];
                n_filt_clip[k] = 1'b0;
            end else begin
                n_filt[k]      = n_sh[k][SH_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                n_filt_clip[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < M; k++) begin
                r_last_raw[k] <= '0;
                r_smoothed[k] <= '0;
            end
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_job   <= i_q.job;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < M; k++) begin
                        r_m[k] <= r_job.mag[k] * evl_pkg::US_PER_MINUTE;
                    end
                    r_den   <= i_cfg.counts_per_rev * r_job.elapsed_us;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!w_div[0].busy && !w_div[1].busy) begin
                        r_state <= S_RAW;
                    end
                end
                S_RAW: begin
                    for (int k = 0; k < M; k++) begin
                        r_raw[k] <= n_raw[k];
                    end
                    r_clip  <= |n_raw_clip;
                    r_state <= S_FMUL;
                end
                S_FMUL: begin
                    for (int k = 0; k < M; k++) begin
                        r_pa[k] <= $signed({1'b0, i_cfg.coef_feedback}) * r_smoothed[k];
                        r_pb[k] <= $signed({1'b0, i_cfg.coef_input}) * n_sum[k];
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    for (int k = 0; k < M; k++) begin
                        r_smoothed[k] <= n_filt[k];
                        r_last_raw[k] <= r_raw[k];
                    end
                    r_clip  <= r_clip | (|n_filt_clip);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_data.rate_left  <= r_smoothed[0];
                        r_out_data.rate_right <= r_smoothed[1];
                        r_out_data.clipped    <= r_clip;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `EVL_ASSERT_NOW(a_div_idle_outside_wait, i_clk, i_rst_n,
        (r_state == S_IDLE || r_state == S_OUT), (!w_div[0].busy && !w_div[1].busy),
        "Divider busy while no item is being divided.")
    `EVL_ASSERT_NOW(a_out_from_out_state, i_clk, i_rst_n,
        $rose(r_out_valid), ($past(r_state) == S_OUT),
        "Result register loaded outside the output state.")
    `EVL_ASSERT_NEXT(a_div_started, i_clk, i_rst_n, (r_state == S_DIV),
        ((w_div[0].busy || w_div[0].sat) && (w_div[1].busy || w_div[1].sat)),
        "Divider did not take the start.")

endmodule

[rtl/encoder_velocity_lowpass_top.sv]
// Encoder velocity low-pass: top level with configuration registers, front end, queue, back end.
// The back end takes one item at a time and finishes it before popping the next; its pace
// is set by the 32-step bit-serial divider (one per motor, both run in parallel), whose
// steps are skipped when a division overflows at the start.
// The queue holds further items while the back end works and its result register waits.
// Synchronous active-low reset restores register defaults and clears counts, rates and queue.
module encoder_velocity_lowpass_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    evl_if.sink   i_in,
    evl_if.source o_out,
    evl_if.sink   i_cfg
);

    evl_pkg::t_cfg_set r_cfg;
    evl_pkg::t_q_wr    w_wr;
    evl_pkg::t_q_rd    w_rd;
    logic              w_full;
    logic              w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.counts_per_rev <= evl_pkg::RST_COUNTS_PER_REV;
            r_cfg.coef_feedback  <= evl_pkg::RST_COEF_FEEDBACK;
            r_cfg.coef_input     <= evl_pkg::RST_COEF_INPUT;
        end else if (i_cfg.valid) begin
            case (evl_pkg::t_cfg_reg'(i_cfg.data.index))
                evl_pkg::CFG_COUNTS_PER_REV: r_cfg.counts_per_rev <= i_cfg.data.value;
                evl_pkg::CFG_COEF_FEEDBACK:  r_cfg.coef_feedback  <= i_cfg.data.value;
                evl_pkg::CFG_COEF_INPUT:     r_cfg.coef_input     <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    evl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_wr    (w_wr)
    );

    evl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rd    (w_rd)
    );

    evl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_rd),
        .o_pop   (w_pop),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );

endmodule
